### sv/assert_macros.svh
// Assertion helpers shared by the bitmap allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define FBA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle, consequent in the next one.
`define FBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/fba_pkg.sv
package fba_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_FRAMES_DEF = 65536;
    localparam int WORD_BITS_DEF  = 64;
    localparam int PAGE_BYTES_DEF = 4096;

    // Fixed field widths.
    localparam int CNT_BITS  = 17;
    localparam int ADDR_BITS = 28;
    localparam int BASE_BITS = 48;
    localparam int LEN_BITS  = 49;
    localparam int LANE_BITS = 8;

    localparam logic [CNT_BITS-1:0] FRAME_COUNT_RESET = 17'h10000;

    // Opcodes.
    localparam logic [2:0] OP_ALL_USED = 3'd0;
    localparam logic [2:0] OP_RELEASE  = 3'd1;
    localparam logic [2:0] OP_RESERVE  = 3'd2;
    localparam logic [2:0] OP_ALLOC    = 3'd3;
    localparam logic [2:0] OP_FREE     = 3'd4;

    // Command beat.
    typedef struct packed {
        logic [2:0]           opcode;
        logic [BASE_BITS-1:0] region_base;
        logic [LEN_BITS-1:0]  region_length;
    } t_cmd;

    // Result beat.
    typedef struct packed {
        logic [ADDR_BITS-1:0] frame_address;
        logic                 granted;
        logic [CNT_BITS-1:0]  free_count;
    } t_result;

endpackage

### sv/fba_ram.sv
module fba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/frame_bitmap_allocator.sv
// Channel   Direction  Handshake                Payload
// command   in         start high, busy low     i_cmd (t_cmd)
// result    out        o_done, one cycle        o_result (t_result)
// config    in         i_cfg_we                 i_cfg_data (frame count)
//
// Range, single-frame and allocation operations walk the bitmap one word at a time
// through the bitmap RAM: read, merge, then count or pick for each word.
// An allocation first reduces its hint modulo the frame count when the hint is too
// large. Marking every frame used writes each bitmap word in turn, and after reset
// a fill pass over all BITMAP_WORDS words (1024 by default) runs before the first
// command. The result strobe lasts one cycle and cannot be stalled; busy stays
// high until the cycle after it. WORD_BITS and PAGE_BYTES must be powers of two.
`include "assert_macros.svh"

module frame_bitmap_allocator
    import fba_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int WORD_BITS  = WORD_BITS_DEF,
    parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  t_cmd                i_cmd,
    output logic                o_done,
    output t_result             o_result,
    input  logic                i_cfg_we,
    input  logic [CNT_BITS-1:0] i_cfg_data
);

    localparam int PB           = $clog2(PAGE_BYTES);
    localparam int BW           = $clog2(WORD_BITS);
    localparam int FW           = $clog2(MAX_FRAMES);
    localparam int CW           = $clog2(MAX_FRAMES + 1);
    localparam int XW           = (CW > CNT_BITS) ? CW : CNT_BITS;
    localparam int BITMAP_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW           = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int SW           = LEN_BITS + 1;
    localparam int FWIDE        = SW - PB;
    localparam int PW           = $clog2(WORD_BITS + 1);
    localparam int LANES        = WORD_BITS / LANE_BITS;
    localparam int LCW          = $clog2(LANE_BITS + 1);
    localparam int AXW          = FW + PB;
    localparam int DIV_IW       = $clog2(CNT_BITS);
    localparam int RESET_USED   = (MAX_FRAMES < 65536) ? MAX_FRAMES : 65536;

    localparam logic [WORD_BITS-1:0] ONES    = {WORD_BITS{1'b1}};
    localparam logic [BW-1:0]        TOP_BIT = BW'(WORD_BITS - 1);

    typedef enum logic [11:0] {
        S_FILL  = 12'b0000_0000_0001,
        S_IDLE  = 12'b0000_0000_0010,
        S_PREP  = 12'b0000_0000_0100,
        S_CLAMP = 12'b0000_0000_1000,
        S_HINT  = 12'b0000_0001_0000,
        S_DIV   = 12'b0000_0010_0000,
        S_SEED  = 12'b0000_0100_0000,
        S_READ  = 12'b0000_1000_0000,
        S_MERGE = 12'b0001_0000_0000,
        S_COUNT = 12'b0010_0000_0000,
        S_PICK  = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } t_state;

    function automatic logic [AW-1:0] word_of(input logic [FW-1:0] f);
        word_of = AW'(f >> BW);
    endfunction

    // Control registers.
    t_state              r_state, n_state;
    logic [CNT_BITS-1:0] r_frame_count, n_frame_count;
    logic [CW-1:0]       r_used, n_used;
    logic [CNT_BITS-1:0] r_hint, n_hint;
    logic [AW-1:0]       r_w, n_w;
    logic                r_fill_op, n_fill_op;
    logic                r_wrapped, n_wrapped;
    logic [DIV_IW-1:0]   r_div_i, n_div_i;

    // Working registers.
    t_cmd                 r_cmd, n_cmd;
    logic [SW-1:0]        r_sum_lo, n_sum_lo;
    logic [SW-1:0]        r_sum_hi, n_sum_hi;
    logic [FW-1:0]        r_lo_f, n_lo_f;
    logic [FW-1:0]        r_hi_f, n_hi_f;
    logic [FW-1:0]        r_start, n_start;
    logic [AW-1:0]        r_w0, n_w0;
    logic [XW-1:0]        r_rem, n_rem;
    logic [WORD_BITS-1:0] r_delta, n_delta;
    logic [WORD_BITS-1:0] r_word, n_word;
    logic [ADDR_BITS-1:0] r_addr, n_addr;
    logic                 r_granted, n_granted;

    // Shared datapath signals.
    logic [XW-1:0]        fc_ext;
    logic [CW-1:0]        cnt;
    logic [AW-1:0]        hi_word;
    logic [WORD_BITS-1:0] lo_mask, hi_mask, span_mask;
    logic [PW-1:0]        pop;
    logic [WORD_BITS-1:0] onehot;
    logic [BW-1:0]        pick_bit;
    logic [FW-1:0]        pick_f;

    // Bitmap RAM port signals.
    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

    fba_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(BITMAP_WORDS)
    ) u_bitmap (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Frame count in force, limited to the bitmap size.
    assign fc_ext = XW'(r_frame_count);
    assign cnt    = (fc_ext > XW'(MAX_FRAMES)) ? CW'(MAX_FRAMES) : CW'(fc_ext);

    // Mask of the bits of the current word that lie in the span [lo, hi].
    assign hi_word   = word_of(r_hi_f);
    assign lo_mask   = (r_w == word_of(r_lo_f)) ? (ONES << r_lo_f[BW-1:0]) : ONES;
    assign hi_mask   = (r_w == hi_word) ? (ONES >> (TOP_BIT - r_hi_f[BW-1:0])) : ONES;
    assign span_mask = lo_mask & hi_mask;

    // Population count of the changed bits, summed per byte lane first.
    always_comb begin
        logic [LCW-1:0] lane_cnt;
        pop = '0;
        for (int l = 0; l < LANES; l++) begin
            lane_cnt = '0;
            for (int b = 0; b < LANE_BITS; b++) begin
                lane_cnt = lane_cnt + LCW'(r_delta[l * LANE_BITS + b]);
            end
            pop = pop + PW'(lane_cnt);
        end
    end

    // Lowest free bit of the candidate word, isolated and encoded.
    assign onehot = r_delta & (~r_delta + WORD_BITS'(1));

    always_comb begin
        pick_bit = '0;
        for (int k = 0; k < WORD_BITS; k++) begin
            if (onehot[k]) begin
                pick_bit = pick_bit | BW'(k);
            end
        end
    end

    assign pick_f = FW'({r_w, pick_bit});

    // Sequencer and datapath next-state logic.
    always_comb begin
        logic [SW-1:0]    b_ext, l_ext, p_ext;
        logic [FWIDE-1:0] first_f, last_f, cnt_w, last_c;
        logic [XW:0]      rem_sh, cnt_x1;
        logic [CW:0]      used_sum;
        logic [AXW-1:0]   addr_full;

        n_state       = r_state;
        n_frame_count = i_cfg_we ? i_cfg_data : r_frame_count;
        n_used        = r_used;
        n_hint        = r_hint;
        n_w           = r_w;
        n_fill_op     = r_fill_op;
        n_wrapped     = r_wrapped;
        n_div_i       = r_div_i;
        n_cmd         = r_cmd;
        n_sum_lo      = r_sum_lo;
        n_sum_hi      = r_sum_hi;
        n_lo_f        = r_lo_f;
        n_hi_f        = r_hi_f;
        n_start       = r_start;
        n_w0          = r_w0;
        n_rem         = r_rem;
        n_delta       = r_delta;
        n_word        = r_word;
        n_addr        = r_addr;
        n_granted     = r_granted;

        ram_we    = 1'b0;
        ram_waddr = r_w;
        ram_wdata = ONES;
        ram_re    = 1'b0;
        ram_raddr = r_w;

        b_ext     = SW'(r_cmd.region_base);
        l_ext     = SW'(r_cmd.region_length);
        p_ext     = SW'(PAGE_BYTES);
        first_f   = FWIDE'(r_sum_lo >> PB);
        last_f    = FWIDE'(r_sum_hi >> PB);
        cnt_w     = FWIDE'(cnt);
        last_c    = (last_f > cnt_w) ? cnt_w : last_f;
        rem_sh    = {r_rem, r_hint[r_div_i]};
        cnt_x1    = (XW + 1)'(cnt);
        used_sum  = (CW + 1)'(r_used) + (CW + 1)'(pop);
        addr_full = AXW'(pick_f) << PB;

        case (r_state)
            // Set every word of the bitmap to all used.
            S_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = r_w;
                ram_wdata = ONES;
                n_w       = r_w + AW'(1);
                if (r_w == AW'(BITMAP_WORDS - 1)) begin
                    n_w       = '0;
                    n_fill_op = 1'b0;
                    if (r_fill_op) begin
                        n_used  = cnt;
                        n_hint  = '0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            // Take a command beat and dispatch on the opcode.
            S_IDLE: begin
                if (start) begin
                    n_cmd     = i_cmd;
                    n_addr    = '0;
                    n_granted = 1'b0;
                    case (i_cmd.opcode)
                        OP_ALL_USED: begin
                            n_w       = '0;
                            n_fill_op = 1'b1;
                            n_state   = S_FILL;
                        end
                        OP_RELEASE, OP_RESERVE, OP_FREE: n_state = S_PREP;
                        OP_ALLOC: n_state = S_HINT;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            // Byte bounds of the span, rounded so that a shift gives frames.
            S_PREP: begin
                case (r_cmd.opcode)
                    OP_RELEASE: begin
                        n_sum_lo = b_ext + p_ext - SW'(1);
                        n_sum_hi = b_ext + l_ext;
                    end
                    OP_RESERVE: begin
                        n_sum_lo = b_ext;
                        n_sum_hi = b_ext + l_ext + p_ext - SW'(1);
                    end
                    default: begin
                        n_sum_lo = b_ext;
                        n_sum_hi = b_ext + p_ext;
                    end
                endcase
                n_state = S_CLAMP;
            end
            // Clip the frame span to the frame count.
            S_CLAMP: begin
                if (first_f >= last_c) begin
                    n_state = S_DONE;
                end else begin
                    n_lo_f  = FW'(first_f);
                    n_hi_f  = FW'(last_c - FWIDE'(1));
                    n_w     = word_of(FW'(first_f));
                    n_state = S_READ;
                end
            end
            // Search start: the hint, reduced modulo the count when needed.
            S_HINT: begin
                if (cnt == '0) begin
                    n_state = S_DONE;
                end else if (XW'(r_hint) < XW'(cnt)) begin
                    n_start = FW'(r_hint);
                    n_state = S_SEED;
                end else begin
                    n_rem   = '0;
                    n_div_i = DIV_IW'(CNT_BITS - 1);
                    n_state = S_DIV;
                end
            end
            // Restoring remainder, one hint bit per cycle.
            S_DIV: begin
                n_rem   = (rem_sh >= cnt_x1) ? XW'(rem_sh - cnt_x1) : XW'(rem_sh);
                n_div_i = r_div_i - DIV_IW'(1);
                if (r_div_i == '0) begin
                    n_start = FW'(n_rem);
                    n_state = S_SEED;
                end
            end
            // Allocation span: from the start frame up to the last frame.
            S_SEED: begin
                n_lo_f    = r_start;
                n_hi_f    = FW'(cnt - CW'(1));
                n_w       = word_of(r_start);
                n_w0      = word_of(r_start);
                n_wrapped = 1'b0;
                n_state   = S_READ;
            end
            S_READ: begin
                ram_re    = 1'b1;
                ram_raddr = r_w;
                n_state   = S_MERGE;
            end
            // Word is back from the RAM: update it or look for a free bit.
            S_MERGE: begin
                n_word = ram_rdata;
                if (r_cmd.opcode == OP_ALLOC) begin
                    n_delta = ~ram_rdata & span_mask;
                    n_state = S_PICK;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_w;
                    if (r_cmd.opcode == OP_RESERVE) begin
                        ram_wdata = ram_rdata | span_mask;
                        n_delta   = span_mask & ~ram_rdata;
                    end else begin
                        ram_wdata = ram_rdata & ~span_mask;
                        n_delta   = span_mask & ram_rdata;
                    end
                    n_state = S_COUNT;
                end
            end
            // Apply the changed-bit count with saturation, then move on.
            S_COUNT: begin
                if (r_cmd.opcode == OP_RESERVE) begin
                    n_used = (used_sum > (CW + 1)'(MAX_FRAMES)) ? CW'(MAX_FRAMES)
                                                                : CW'(used_sum);
                end else begin
                    n_used = (r_used >= CW'(pop)) ? (r_used - CW'(pop)) : '0;
                end
                if (r_w == hi_word) begin
                    n_state = S_DONE;
                end else begin
                    n_w     = r_w + AW'(1);
                    n_state = S_READ;
                end
            end
            // Grant the lowest free frame, or step to the next word with wrap.
            S_PICK: begin
                if (r_delta != '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_w;
                    ram_wdata = r_word | onehot;
                    if (r_used < CW'(MAX_FRAMES)) begin
                        n_used = r_used + CW'(1);
                    end
                    n_hint    = CNT_BITS'(XW'(pick_f) + XW'(1));
                    n_addr    = ADDR_BITS'(addr_full);
                    n_granted = 1'b1;
                    n_state   = S_DONE;
                end else if (r_wrapped && (r_w == r_w0)) begin
                    n_state = S_DONE;
                end else begin
                    n_lo_f = '0;
                    if (r_w == hi_word) begin
                        n_w       = '0;
                        n_wrapped = 1'b1;
                    end else begin
                        n_w = r_w + AW'(1);
                    end
                    n_state = S_READ;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state, with synchronous reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_FILL;
            r_frame_count <= FRAME_COUNT_RESET;
            r_used        <= CW'(RESET_USED);
            r_hint        <= '0;
            r_w           <= '0;
            r_fill_op     <= 1'b0;
            r_wrapped     <= 1'b0;
            r_div_i       <= '0;
        end else begin
            r_state       <= n_state;
            r_frame_count <= n_frame_count;
            r_used        <= n_used;
            r_hint        <= n_hint;
            r_w           <= n_w;
            r_fill_op     <= n_fill_op;
            r_wrapped     <= n_wrapped;
            r_div_i       <= n_div_i;
        end
    end

    // Working registers, no reset needed.
    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_sum_lo  <= n_sum_lo;
        r_sum_hi  <= n_sum_hi;
        r_lo_f    <= n_lo_f;
        r_hi_f    <= n_hi_f;
        r_start   <= n_start;
        r_w0      <= n_w0;
        r_rem     <= n_rem;
        r_delta   <= n_delta;
        r_word    <= n_word;
        r_addr    <= n_addr;
        r_granted <= n_granted;
    end

    // Result beat and handshake outputs.
    assign busy                   = (r_state != S_IDLE);
    assign o_done                 = (r_state == S_DONE);
    assign o_result.frame_address = r_addr;
    assign o_result.granted       = r_granted;
    assign o_result.free_count    = (cnt > r_used) ? CNT_BITS'(cnt - r_used) : '0;

    `FBA_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done, "strobe held too long")
    `FBA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "idle after accept")
    `FBA_ASSERT(a_used_bound, i_clk, i_rst_n, r_used <= CW'(MAX_FRAMES), "used count too large")
    `FBA_ASSERT(a_state_onehot, i_clk, i_rst_n, $onehot(r_state), "state not one-hot")

endmodule
